@@ rtl/csr_urw_pkg.sv @@
`default_nettype none

package csr_urw_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 8192;
  localparam int MAX_STEPS = 63;

  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 13;
  localparam int DATA_W   = 14;
  localparam int START_W  = 10;
  localparam int NODE_W   = 11;
  localparam int STEP_W   = 6;
  localparam int RNG_W    = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam int RP_AW  = $clog2(MAX_NODES + 1);
  localparam int NB_AW  = $clog2(MAX_EDGES);
  localparam int NB_DW  = $clog2(MAX_NODES);
  localparam int OFF_W  = DATA_W;
  localparam int DIV_CNT_W = $clog2(RNG_W);

  localparam logic [KIND_W-1:0] KIND_ROW  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NBR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WALK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WALK_STEPS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED   = 1'd1;

  localparam logic [RNG_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic signed [NODE_W-1:0] NODE_DEAD = -11'sd1;
  localparam logic [STEP_W-1:0] WALK_STEPS_RST = 6'd8;

  typedef struct packed {
    logic             start;
    logic [RNG_W-1:0] dividend;
    logic [OFF_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [OFF_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [OFF_W-1:0] clamp_offset(input logic [OFF_W-1:0] v);
    logic [OFF_W-1:0] lim;
    lim = OFF_W'(MAX_EDGES);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [RNG_W-1:0] lfsr_next(input logic [RNG_W-1:0] r);
    logic [RNG_W-1:0] s;
    s = r >> 1;
    return r[0] ? (s ^ LFSR_TAPS) : s;
  endfunction

  function automatic logic [RNG_W-1:0] seed_value(input logic [RNG_W-1:0] s);
    return (s == '0) ? RNG_W'(1) : s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/csr_uniform_random_walk.sv @@
`default_nettype none

// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_ready    in_kind, in_table_addr, in_table_data, in_start_node
// out      out  out_valid / out_ready  out_node, out_step, out_last
// cfg      in   cfg_we                 cfg_index, cfg_data
//
// Load transactions leave in_ready high. A step to a node with neighbors goes through
// row pointer reads and degree check, the single 32-iteration divider and a neighbor read
// before its emit. A step that finds a dead end goes through the row pointer reads and
// degree check only; once dead, a step is only its emit. Synchronous active-low reset;
// tables are not cleared.
// in_ready is low while a walk runs; out_ready low holds the walk at its next emit.
module csr_uniform_random_walk (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [csr_urw_pkg::KIND_W-1:0]       in_kind,
  input  wire logic [csr_urw_pkg::ADDR_W-1:0]       in_table_addr,
  input  wire logic [csr_urw_pkg::DATA_W-1:0]       in_table_data,
  input  wire logic [csr_urw_pkg::START_W-1:0]      in_start_node,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [csr_urw_pkg::NODE_W-1:0]     out_node,
  output logic [csr_urw_pkg::STEP_W-1:0]            out_step,
  output logic                                      out_last,
  input  wire logic                                 cfg_we,
  input  wire logic [csr_urw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [csr_urw_pkg::CFG_W-1:0]        cfg_data
);
  import csr_urw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EMIT, S_RD_LO, S_RD_HI, S_CHK, S_DIV, S_NB1, S_NB2
  } state_t;

  state_t                   state_r;
  logic [STEP_W-1:0]        walk_steps_r;
  logic [RNG_W-1:0]         lfsr_r;
  logic [NB_DW-1:0]         cur_r;
  logic                     dead_r;
  logic [STEP_W-1:0]        k_r;
  logic [STEP_W-1:0]        steps_r;
  logic [OFF_W-1:0]         lo_r;
  logic [NB_AW-1:0]         idx_r;
  logic                     out_valid_r;
  logic signed [NODE_W-1:0] out_node_r;
  logic [STEP_W-1:0]        out_step_r;
  logic                     out_last_r;

  logic [OFF_W-1:0] rp_mem [MAX_NODES+1];
  logic [NB_DW-1:0] nb_mem [MAX_EDGES];
  logic [OFF_W-1:0] rp_q_r;
  logic [NB_DW-1:0] nb_q_r;
  logic [RP_AW-1:0] rp_raddr;

  logic             in_acc;
  logic             emit_ok;
  logic             emit_go;
  logic [OFF_W-1:0] hi;
  logic             has_nbr;
  mod_req_t         mreq;
  mod_rsp_t         mrsp;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign emit_ok  = !out_valid_r || out_ready;
  assign emit_go  = (state_r == S_EMIT) && emit_ok;

  always_comb begin
    rp_raddr = (state_r == S_RD_HI) ? (RP_AW'(cur_r) + RP_AW'(1)) : RP_AW'(cur_r);
    hi       = clamp_offset(rp_q_r);
    has_nbr  = hi > lo_r;
    mreq.start    = (state_r == S_CHK) && has_nbr;
    mreq.dividend = lfsr_next(lfsr_r);
    mreq.divisor  = hi - lo_r;
  end

  csr_urw_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  always_ff @(posedge clk) begin
    if (in_acc && in_kind == KIND_ROW && in_table_addr <= ADDR_W'(MAX_NODES)) begin
      rp_mem[in_table_addr[RP_AW-1:0]] <= in_table_data;
    end
    if (in_acc && in_kind == KIND_NBR) begin
      nb_mem[in_table_addr[NB_AW-1:0]] <= in_table_data[NB_DW-1:0];
    end
    rp_q_r <= rp_mem[rp_raddr];
    nb_q_r <= nb_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      walk_steps_r <= WALK_STEPS_RST;
      lfsr_r       <= RNG_W'(1);
      cur_r        <= '0;
      dead_r       <= 1'b0;
      k_r          <= '0;
      steps_r      <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= emit_go || (out_valid_r && !out_ready);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WALK_STEPS: walk_steps_r <= cfg_data[STEP_W-1:0];
          CFG_RNG_SEED:   lfsr_r       <= seed_value(cfg_data);
          default:        ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_kind == KIND_WALK) begin
            cur_r   <= in_start_node;
            dead_r  <= 1'b0;
            k_r     <= '0;
            steps_r <= (walk_steps_r > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
                                                            : walk_steps_r;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_node_r  <= dead_r ? NODE_DEAD : $signed({1'b0, cur_r});
            out_step_r  <= k_r;
            out_last_r  <= (k_r == steps_r);
            if (k_r == steps_r) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + STEP_W'(1);
              state_r <= dead_r ? S_EMIT : S_RD_LO;
            end
          end
        end
        S_RD_LO: state_r <= S_RD_HI;
        S_RD_HI: begin
          lo_r    <= clamp_offset(rp_q_r);
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (has_nbr) begin
            lfsr_r  <= lfsr_next(lfsr_r);
            state_r <= S_DIV;
          end else begin
            dead_r  <= 1'b1;
            state_r <= S_EMIT;
          end
        end
        S_DIV: begin
          if (mrsp.done) begin
            idx_r   <= NB_AW'(lo_r + mrsp.rem);
            state_r <= S_NB1;
          end
        end
        S_NB1: state_r <= S_NB2;
        S_NB2: begin
          cur_r   <= nb_q_r;
          state_r <= S_EMIT;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_node  = out_node_r;
  assign out_step  = out_step_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

@@ rtl/csr_urw_mod.sv @@
`default_nettype none

module csr_urw_mod (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire csr_urw_pkg::mod_req_t req,
  output csr_urw_pkg::mod_rsp_t      rsp
);
  import csr_urw_pkg::*;

  logic [RNG_W-1:0]     dvd_r;
  logic [OFF_W-1:0]     dsr_r;
  logic [OFF_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [OFF_W:0]   trial;
  logic [OFF_W:0]   diff;
  logic [OFF_W-1:0] rem_nxt;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, dvd_r[RNG_W-1]};
    diff    = trial - {1'b0, dsr_r};
    rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[OFF_W-1:0] : trial[OFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= req.dividend;
        dsr_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(RNG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

@@ rtl/csr_urw_chk.sv @@
`default_nettype none

module csr_urw_chk (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic [csr_urw_pkg::KIND_W-1:0]       in_kind,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [csr_urw_pkg::NODE_W-1:0] out_node,
  input wire logic [csr_urw_pkg::STEP_W-1:0]       out_step,
  input wire logic                                 out_last
);
  import csr_urw_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node) && $stable(out_step)
      && $stable(out_last))
    else $error("result changed while stalled");

  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_WALK |=> !in_ready)
    else $error("input ready right after walk start");

  a_mid_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in middle of walk");

  a_step_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      !out_valid || out_step == $past(out_step) + STEP_W'(1))
    else $error("step not consecutive");

  a_step_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid || out_step == '0)
    else $error("new walk does not start at step zero");

endmodule

bind csr_uniform_random_walk csr_urw_chk u_chk (.*);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import csr_urw_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam logic [RNG_W-1:0]  TAP_MASK  = 32'h8020_0003;
  localparam int                NO_HOP    = int'(NODE_DEAD);
  localparam int                PHASES    = 6;
  localparam int                PHASE_OPS = 14;
  localparam int                GRAPH_NODES = 16;
  localparam int                GRAPH_DEG   = 4;
  localparam int                NBR_PAD_W   = DATA_W - NB_DW;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic [ADDR_W-1:0]        addr;
    logic [DATA_W-1:0]        data;
    logic [START_W-1:0]       start;
    bit                       lit;
    logic signed [NODE_W-1:0] first_hop;
  } csr_op_t;

  typedef struct packed {
    logic signed [NODE_W-1:0] node;
    logic [STEP_W-1:0]        step;
    logic                     last;
  } visit_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [ADDR_W-1:0]     in_table_addr = '0;
  logic [DATA_W-1:0]     in_table_data = '0;
  logic [START_W-1:0]    in_start_node = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [NODE_W-1:0] out_node;
  logic [STEP_W-1:0]     out_step;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // shadow state of the walker
  logic [DATA_W-1:0]     rp_shadow [0:MAX_NODES];
  logic [NB_DW-1:0]      nb_shadow [0:MAX_EDGES-1];
  logic [RNG_W-1:0]      rng_shadow = 32'd1;
  logic [STEP_W-1:0]     walk_len = WALK_STEPS_RST;

  visit_t                visits_due [$];

  int unsigned           send_pct = 0;
  int unsigned           rcv_pct = 0;
  logic                  hold_go = 1'b0;
  int                    fails = 0;
  int                    walks_run = 0;
  int                    loads_done = 0;
  int                    visits_seen = 0;
  int                    dead_seen = 0;

  int unsigned send_mix [PHASES] = '{0, 61, 0, 6, 61, 0};
  int unsigned rcv_mix  [PHASES] = '{0, 0, 61, 6, 0, 61};

  csr_op_t dir_ops [24] = '{
    '{KIND_ROW,  13'd6,    14'd20,    10'd0,    1'b0, NODE_DEAD},
    '{KIND_WALK, 13'd0,    14'd0,     10'd5,    1'b1, NODE_DEAD},
    '{KIND_ROW,  13'd1023, 14'd8191,  10'd0,    1'b0, NODE_DEAD},
    '{KIND_ROW,  13'd1024, 14'd16383, 10'd0,    1'b0, NODE_DEAD},
    '{KIND_NBR,  13'd8191, 14'd16383, 10'd0,    1'b0, NODE_DEAD},
    '{KIND_WALK, 13'd0,    14'd0,     10'd1023, 1'b0, NODE_DEAD},
    '{KIND_ROW,  13'd8191, 14'd0,     10'd0,    1'b0, NODE_DEAD},
    '{KIND_ROW,  13'd1025, 14'd8192,  10'd0,    1'b0, NODE_DEAD},
    '{KIND_NBR,  13'd0,    14'd0,     10'd0,    1'b0, NODE_DEAD},
    '{KIND_WALK, 13'd0,    14'd0,     10'd0,    1'b0, NODE_DEAD},
    '{KIND_NONE, 13'd8191, 14'd16383, 10'd1023, 1'b0, NODE_DEAD},
    '{KIND_ROW,  13'd10,   14'd9000,  10'd0,    1'b0, NODE_DEAD},
    '{KIND_ROW,  13'd11,   14'd12000, 10'd0,    1'b0, NODE_DEAD},
    '{KIND_WALK, 13'd0,    14'd0,     10'd10,   1'b1, NODE_DEAD},
    '{KIND_ROW,  13'd10,   14'd40,    10'd0,    1'b0, NODE_DEAD},
    '{KIND_ROW,  13'd11,   14'd44,    10'd0,    1'b0, NODE_DEAD},
    '{KIND_ROW,  13'd20,   14'd200,   10'd0,    1'b0, NODE_DEAD},
    '{KIND_ROW,  13'd21,   14'd100,   10'd0,    1'b0, NODE_DEAD},
    '{KIND_WALK, 13'd0,    14'd0,     10'd20,   1'b1, NODE_DEAD},
    '{KIND_ROW,  13'd30,   14'd240,   10'd0,    1'b0, NODE_DEAD},
    '{KIND_ROW,  13'd31,   14'd241,   10'd0,    1'b0, NODE_DEAD},
    '{KIND_NBR,  13'd240,  14'h3C05,  10'd0,    1'b0, NODE_DEAD},
    '{KIND_WALK, 13'd0,    14'd0,     10'd30,   1'b1, 11'sd5},
    '{KIND_WALK, 13'd0,    14'd0,     10'd9,    1'b0, NODE_DEAD}
  };

  csr_uniform_random_walk u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_table_addr (in_table_addr),
    .in_table_data (in_table_data),
    .in_start_node (in_start_node),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_node      (out_node),
    .out_step      (out_step),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // next node of a uniform walk, advancing the LFSR only on a real pick
  function automatic int pick_hop(input int cur);
    int unsigned lo, hi;
    lo = rp_shadow[cur];
    hi = rp_shadow[cur + 1];
    if (lo > MAX_EDGES) lo = MAX_EDGES;
    if (hi > MAX_EDGES) hi = MAX_EDGES;
    if (hi <= lo) return NO_HOP;
    rng_shadow = {1'b0, rng_shadow[RNG_W-1:1]} ^ (rng_shadow[0] ? TAP_MASK : '0);
    return int'(nb_shadow[lo + rng_shadow % (hi - lo)]);
  endfunction

  // neighbor word: a node of the loaded graph, junk in the unused upper bits
  function automatic logic [DATA_W-1:0] nbr_word();
    return {NBR_PAD_W'($urandom), NB_DW'($urandom_range(GRAPH_NODES - 1))};
  endfunction

  task automatic track_txn(input csr_op_t op, input bit queue_it);
    int     cur;
    visit_t v;
    case (op.kind)
      KIND_ROW: begin
        loads_done++;
        if (op.addr <= MAX_NODES) rp_shadow[op.addr] = op.data;
      end
      KIND_NBR: begin
        loads_done++;
        if (op.addr < MAX_EDGES) nb_shadow[op.addr] = op.data[NB_DW-1:0];
      end
      KIND_WALK: begin
        walks_run++;
        cur = int'(op.start);
        for (int k = 0; k <= walk_len; k++) begin
          if (k > 0 && cur != NO_HOP) cur = pick_hop(cur);
          v.node = NODE_W'(cur);
          v.step = STEP_W'(k);
          v.last = (k == walk_len);
          if (queue_it) visits_due.push_back(v);
        end
      end
      default: ;
    endcase
  endtask

  task automatic offer(input csr_op_t op);
    visit_t v;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= op.kind;
    in_table_addr <= op.addr;
    in_table_data <= op.data;
    in_start_node <= op.start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_txn(op, !op.lit);
    if (op.lit) begin
      for (int k = 0; k <= walk_len; k++) begin
        v.node = (k == 0) ? NODE_W'(op.start) : (k == 1) ? op.first_hop : NODE_DEAD;
        v.step = STEP_W'(k);
        v.last = (k == walk_len);
        visits_due.push_back(v);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (visits_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic program_walk(input logic [STEP_W-1:0] steps, input logic [RNG_W-1:0] seed);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WALK_STEPS;
    cfg_data  <= {26'($urandom), steps};
    @(posedge clk);
    walk_len   = steps;
    cfg_index <= CFG_RNG_SEED;
    cfg_data  <= seed;
    @(posedge clk);
    rng_shadow = (seed == '0) ? 32'd1 : seed;
    cfg_we    <= 1'b0;
  endtask

  function automatic csr_op_t draw_op(output bit counted);
    csr_op_t     op;
    int unsigned sel;
    sel          = $urandom_range(99);
    op.addr      = ADDR_W'($urandom);
    op.data      = DATA_W'($urandom);
    op.start     = START_W'($urandom_range(GRAPH_NODES - 1));
    op.lit       = 1'b0;
    op.first_hop = NODE_DEAD;
    counted      = 1'b1;
    if (sel < 60) begin
      op.kind = KIND_WALK;
    end else if (sel < 80) begin
      op.kind = KIND_ROW;
      op.addr = ADDR_W'($urandom_range(GRAPH_NODES));
      // mostly restore the nominal offset, sometimes move it inside the edge range
      if (sel < 75) op.data = DATA_W'(op.addr * GRAPH_DEG);
      else          op.data = DATA_W'($urandom_range(GRAPH_NODES * GRAPH_DEG));
    end else if (sel < 84) begin
      op.kind = KIND_ROW;
      op.addr = ADDR_W'($urandom_range(8191, MAX_NODES + 1));
      counted = 1'b0;
    end else if (sel < 97) begin
      op.kind = KIND_NBR;
      op.data = nbr_word();
    end else begin
      op.kind = KIND_NONE;
      counted = 1'b0;
    end
    return op;
  endfunction

  // receiver: random backpressure, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        out_ready <= 1'b0;
        hold_go   <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_pct);
      end
    end
  end

  always @(posedge clk) begin
    visit_t want;
    if (rst_n && out_valid && out_ready) begin
      if (visits_due.size() == 0) begin
        $error("unexpected transaction: node %0d step %0d last %0b",
               out_node, out_step, out_last);
        fails++;
      end else begin
        want = visits_due.pop_front();
        visits_seen++;
        if (want.node == NODE_DEAD) dead_seen++;
        if (out_node !== want.node) begin
          $error("node: expected %0d, got %0d", want.node, out_node);
          fails++;
        end
        if (out_step !== want.step) begin
          $error("step: expected %0d, got %0d", want.step, out_step);
          fails++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          fails++;
        end
      end
    end
  end

  initial begin
    csr_op_t           op;
    bit                counted;
    int                n;
    int unsigned       w;
    logic [STEP_W-1:0] steps;
    logic [RNG_W-1:0]  seed;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // small graph: GRAPH_NODES nodes of degree GRAPH_DEG, every edge written
    op.lit       = 1'b0;
    op.first_hop = NODE_DEAD;
    op.start     = '0;
    op.kind      = KIND_ROW;
    for (int i = 0; i <= GRAPH_NODES; i++) begin
      op.addr = ADDR_W'(i);
      op.data = DATA_W'(i * GRAPH_DEG);
      offer(op);
    end
    op.kind = KIND_NBR;
    for (int i = 0; i < GRAPH_NODES * GRAPH_DEG; i++) begin
      op.addr = ADDR_W'(i);
      op.data = nbr_word();
      offer(op);
    end

    foreach (dir_ops[i]) offer(dir_ops[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      send_pct = send_mix[ph];
      rcv_pct  = rcv_mix[ph];
      case (ph)
        0: begin steps = 6'd1;  seed = 32'd0; end
        1: begin steps = 6'd63; seed = 32'hFFFF_FFFF; end
        2: begin steps = 6'd0;  seed = $urandom; end
        default: begin
          steps = STEP_W'($urandom_range(62, 2));
          seed  = $urandom;
        end
      endcase
      program_walk(steps, seed);
      if (ph == 3) hold_go <= 1'b1;
      n = 0;
      while (n < PHASE_OPS) begin
        op = draw_op(counted);
        offer(op);
        if (counted) n++;
      end
    end

    in_valid <= 1'b0;
    for (w = 0; visits_due.size() != 0 && w < 400000; w++) @(posedge clk);
    if (visits_due.size() != 0) begin
      $error("%0d expected transactions never arrived", visits_due.size());
      fails++;
    end
    repeat (200) @(posedge clk);

    $display("Ran %0d walks and %0d table loads; %0d visits checked, %0d of them dead ends.",
             walks_run, loads_done, visits_seen, dead_seen);
    $display("Walk lengths 0 to 63, zero and full seeds, four idle mixes and one long hold.");
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
